@@ sv/dss_pkg.sv @@
// Shared constants, command codes and control/status types for the
// deduplicating set store. No dependencies.
`timescale 1ns / 1ps

package dss_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int ITEM_WIDTH  = 32;
  localparam int CMD_WIDTH   = 2;
  localparam int COUNT_WIDTH = 5;

  localparam logic [CMD_WIDTH-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_QUERY  = 2'd2;

  typedef struct packed {
    logic load;
    logic scan;
    logic shift;
    logic commit;
  } dss_ctl_t;

  typedef struct packed {
    logic scan_done;
    logic hit_now;
    logic is_remove;
    logic shift_done;
  } dss_sts_t;

endpackage

@@ sv/dss_if.sv @@
// Valid/ready channel interfaces for the command and result items.
// Depends on dss_pkg for field widths.
`timescale 1ns / 1ps

interface dss_req_if;
  logic                            valid;
  logic                            ready;
  logic [dss_pkg::CMD_WIDTH-1:0]   cmd;
  logic signed [dss_pkg::ITEM_WIDTH-1:0] item;

  modport source (output valid, cmd, item, input ready);
  modport sink (input valid, cmd, item, output ready);
endinterface

interface dss_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic                            changed;
  logic                            full_error;
  logic [dss_pkg::COUNT_WIDTH-1:0] count;

  modport source (output valid, hit, changed, full_error, count, input ready);
  modport sink (input valid, hit, changed, full_error, count, output ready);
endinterface

@@ sv/dss_dp.sv @@
// Datapath of the set store: entry memory, scan and shift counters, result register.
// Depends on dss_pkg for widths, command codes and control/status types.
`timescale 1ns / 1ps

module dss_dp #(
  parameter int CAPACITY    = dss_pkg::CAPACITY,
  parameter int VALUE_WIDTH = dss_pkg::VALUE_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  dss_pkg::dss_ctl_t                     ctl,
  output dss_pkg::dss_sts_t                     sts,
  input  logic [dss_pkg::CMD_WIDTH-1:0]         cmd,
  input  logic [dss_pkg::ITEM_WIDTH-1:0]        item,
  output logic                                  hit,
  output logic                                  changed,
  output logic                                  full_error,
  output logic [dss_pkg::COUNT_WIDTH-1:0]       count
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];

  logic [dss_pkg::CMD_WIDTH-1:0] op;
  logic [VALUE_WIDTH-1:0]        val;
  logic [VALUE_WIDTH-1:0]        rd_data;
  logic [CNT_W-1:0]              used;
  logic [CNT_W-1:0]              idx;
  logic [CNT_W-1:0]              rd_idx;
  logic                          rd_ok;
  logic                          found;

  logic [VALUE_WIDTH+dss_pkg::ITEM_WIDTH-1:0] item_ext;
  logic [CNT_W-1:0]              rd_idx_m1;
  logic [CNT_W-1:0]              used_next;
  logic [CNT_W+dss_pkg::COUNT_WIDTH-1:0] used_ext;
  logic                          hit_now;
  logic                          rd_go;
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_addr;
  logic [VALUE_WIDTH-1:0]        wr_data;
  logic                          ins_ok;
  logic                          ins_full;
  logic                          rem_ok;

  assign item_ext  = {{VALUE_WIDTH{1'b0}}, item};
  assign rd_idx_m1 = rd_idx - ONE_CNT;
  assign hit_now   = rd_ok && (rd_data == val);
  assign rd_go     = ((ctl.scan && !hit_now) || ctl.shift) && (idx < used);

  assign ins_ok   = (op == dss_pkg::CMD_INSERT) && !found && (used < CAP_CNT);
  assign ins_full = (op == dss_pkg::CMD_INSERT) && !found && (used >= CAP_CNT);
  assign rem_ok   = (op == dss_pkg::CMD_REMOVE) && found;

  always_comb begin
    used_next = used;
    if (ins_ok) begin
      used_next = used + ONE_CNT;
    end else if (rem_ok) begin
      used_next = used - ONE_CNT;
    end
  end

  assign used_ext = {{dss_pkg::COUNT_WIDTH{1'b0}}, used_next};

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx[IDX_W-1:0];
    wr_data = rd_data;
    if (ctl.shift && rd_ok) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx_m1[IDX_W-1:0];
    end else if (ctl.commit && ins_ok) begin
      wr_en   = 1'b1;
      wr_addr = used[IDX_W-1:0];
      wr_data = val;
    end
  end

  assign sts.scan_done  = hit_now || (!rd_ok && (idx >= used));
  assign sts.hit_now    = hit_now;
  assign sts.is_remove  = (op == dss_pkg::CMD_REMOVE);
  assign sts.shift_done = !rd_ok && (idx >= used);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_go) begin
      rd_data <= mem[idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      rd_ok <= 1'b0;
      found <= 1'b0;
    end else begin
      if (ctl.load) begin
        rd_ok <= 1'b0;
        found <= 1'b0;
      end else if (ctl.scan && hit_now) begin
        rd_ok <= 1'b0;
        found <= 1'b1;
      end else if (ctl.scan || ctl.shift) begin
        rd_ok <= rd_go;
      end
      if (ctl.commit) begin
        used <= used_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op  <= cmd;
      val <= item_ext[VALUE_WIDTH-1:0];
      idx <= '0;
    end else if (ctl.scan && hit_now) begin
      idx <= rd_idx + ONE_CNT;
    end else if (rd_go) begin
      idx <= idx + ONE_CNT;
    end
    if (rd_go) begin
      rd_idx <= idx;
    end
    if (ctl.commit) begin
      hit        <= found;
      changed    <= ins_ok || rem_ok;
      full_error <= ins_full;
      count      <= used_ext[dss_pkg::COUNT_WIDTH-1:0];
    end
  end

endmodule

@@ sv/dss_ctrl.sv @@
// Controller state machine of the set store: sequences load, scan, shift and commit.
// Depends on dss_pkg for the control and status types.
`timescale 1ns / 1ps

module dss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output dss_pkg::dss_ctl_t ctl,
  input  dss_pkg::dss_sts_t sts
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    SHIFT,
    FINISH
  } state_t;

  state_t state;

  assign in_ready = (state == IDLE);

  always_comb begin
    ctl = '0;
    unique case (state)
      IDLE:   ctl.load   = in_valid;
      SCAN:   ctl.scan   = 1'b1;
      SHIFT:  ctl.shift  = 1'b1;
      FINISH: ctl.commit = !out_valid || out_ready;
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (ctl.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            state <= SCAN;
          end
        end
        SCAN: begin
          if (sts.scan_done) begin
            state <= (sts.hit_now && sts.is_remove) ? SHIFT : FINISH;
          end
        end
        SHIFT: begin
          if (sts.shift_done) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (ctl.commit) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

@@ sv/dedup_set_store.sv @@
// Top level of the deduplicating set store.
// Depends on dss_pkg, dss_if, dss_ctrl and dss_dp.
//
// Commands arrive on req (cmd, item) and one result per command leaves on rsp
// (hit, changed, full_error, count). Both channels move an item when valid and
// ready are high at a rising clock edge.
// A command is taken only while the block is idle. It then scans the stored
// entries one per cycle from the entry memory, whose single read port sets the
// pace. A scan ends at the first hit or after the last stored entry. A remove
// of a present value then moves the later entries down by one position, and
// the result register is written last.
// The result register lets the next command be taken and scanned while a
// result still waits; a stalled receiver holds the block only when the next
// result is ready to be written.
// Synchronous reset empties the store and drops any pending result. The entry
// memory is not cleared, since only entries below the count are ever read.
`timescale 1ns / 1ps

module dedup_set_store #(
  parameter int CAPACITY    = dss_pkg::CAPACITY,
  parameter int VALUE_WIDTH = dss_pkg::VALUE_WIDTH
) (
  input  logic     clk,
  input  logic     rst,
  dss_req_if.sink  req,
  dss_rsp_if.source rsp
);

  dss_pkg::dss_ctl_t ctl;
  dss_pkg::dss_sts_t sts;

  dss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  dss_dp #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .cmd        (req.cmd),
    .item       (req.item),
    .hit        (rsp.hit),
    .changed    (rsp.changed),
    .full_error (rsp.full_error),
    .count      (rsp.count)
  );

endmodule
